@@ rtl/core/assert_macros.svh @@
// Assertion helpers used by distance_power_weighted_fill.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/dpwf_pkg.sv @@
package dpwf_pkg;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    REG_GRID_WIDTH,
    REG_GRID_HEIGHT,
    REG_ELECTRODE_COUNT
  } cfg_reg_t;

  localparam logic [16:0] WEIGHT_ONE   = 17'd65536;
  localparam int          WEIGHT_POWER = 20;
  localparam int          SQRT_STEPS   = 26;
  localparam int          DIV_STEPS    = 16;
  localparam int          SUM_MAX      = 8388607;
  localparam int          SUM_MIN      = -8388608;

endpackage

@@ rtl/core/distance_power_weighted_fill.sv @@
// Distance-weighted interpolation engine for topographic maps.
// The input channel (in_valid/in_ready) carries one transaction per item.
// A load (opcode 0) writes x, y and value into slot entry_index of the
// electrode table. A query (opcode 1) names a pixel and yields one
// transaction on the output channel (out_valid/out_ready): the sum of
// value * (1 - d/D)^20 over the first electrode_count entries, rounded
// and saturated to Q4.20, with a saturation flag.
// Each electrode passes through the shared square root unit and, when d
// is below D, through the shared divider and the single multiplier that
// forms the twentieth power. The block takes no new transaction during
// a query.
// The result sits in an output register; loads are accepted while it waits.
// When the receiver stalls, a finished query waits until the register frees.
// Reset (rst, synchronous) returns to idle, drops a pending result and sets
// the registers to 64, 64 and 0. The table is not cleared; slots must be
// loaded before a query reads them.
`include "assert_macros.svh"
module distance_power_weighted_fill
  import dpwf_pkg::*;
#(
  parameter int MAX_ELECTRODES = 128,
  parameter int COORD_BITS     = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               opcode,
  input  logic [6:0]         entry_index,
  input  logic [7:0]         elec_x,
  input  logic [7:0]         elec_y,
  input  logic signed [23:0] elec_value,
  input  logic [7:0]         pixel_x,
  input  logic [7:0]         pixel_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] pixel_value,
  output logic               saturated
);

  localparam int AW    = (MAX_ELECTRODES > 1) ? $clog2(MAX_ELECTRODES) : 1;
  localparam int ACC_W = 42 + AW;
  localparam logic [7:0] CMASK =
    (COORD_BITS >= 8) ? 8'hFF : 8'((1 << COORD_BITS) - 1);
  localparam logic [AW:0] MAX_CNT = (AW + 1)'(MAX_ELECTRODES);

  typedef enum logic [3:0] {
    S_IDLE, S_GW, S_GH, S_FETCH, S_DX, S_DY, S_DADD, S_SQRT,
    S_CMP, S_DIV, S_POWMUL, S_POWADD, S_MACMUL, S_MACADD, S_FINISH
  } state_t;

  state_t state;

  logic [8:0]  grid_width, grid_height;
  logic [7:0]  electrode_count;

  logic [39:0] mem [MAX_ELECTRODES];
  logic [39:0] rd_data;

  logic [7:0]  px, py;
  logic [AW:0] count_q, idx;
  logic        sq_diag;
  logic [4:0]  step;
  logic [18:0] d2;
  logic [51:0] rad;
  logic [28:0] sq_rem;
  logic [25:0] root, dq_diag, div_rem;
  logic [15:0] quo;
  logic [16:0] w, base;
  logic signed [42:0] prod;
  logic signed [ACC_W-1:0] acc;

  logic signed [24:0] mul_a;
  logic signed [17:0] mul_b;
  logic [7:0]  ex, ey, dx, dy;
  logic signed [23:0] ev;
  logic [28:0] rem_sh, trial;
  logic        sq_ge;
  logic [28:0] sq_rem_next;
  logic [25:0] root_next;
  logic [26:0] dv_sh;
  logic        dv_ge;
  logic [15:0] quo_next;
  logic [25:0] div_rem_next;
  logic signed [ACC_W-1:0] sum_full;
  logic signed [23:0] sum_sat;
  logic        sum_clip;
  logic [31:0] cnt_ext, wr_ext;
  logic [AW:0] count_eff;

  assign in_ready = (state == S_IDLE);
  assign ex = rd_data[39:32];
  assign ey = rd_data[31:24];
  assign ev = rd_data[23:0];
  assign dx = (ex > px) ? ex - px : px - ex;
  assign dy = (ey > py) ? ey - py : py - ey;

  always_comb begin
    case (state)
      S_GW: begin
        mul_a = $signed({16'b0, grid_width});
        mul_b = $signed({9'b0, grid_width});
      end
      S_GH: begin
        mul_a = $signed({16'b0, grid_height});
        mul_b = $signed({9'b0, grid_height});
      end
      S_DX: begin
        mul_a = $signed({17'b0, dx});
        mul_b = $signed({10'b0, dx});
      end
      S_DY: begin
        mul_a = $signed({17'b0, dy});
        mul_b = $signed({10'b0, dy});
      end
      S_POWMUL: begin
        mul_a = $signed({8'b0, w});
        mul_b = $signed({1'b0, base});
      end
      S_MACMUL: begin
        mul_a = {ev[23], ev};
        mul_b = $signed({1'b0, w});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    rem_sh      = {sq_rem[26:0], rad[51:50]};
    trial       = {1'b0, root, 2'b01};
    sq_ge       = (rem_sh >= trial);
    sq_rem_next = sq_ge ? rem_sh - trial : rem_sh;
    root_next   = {root[24:0], sq_ge};
    dv_sh        = {div_rem, 1'b0};
    dv_ge        = (dv_sh >= {1'b0, dq_diag});
    div_rem_next = dv_ge ? 26'(dv_sh - {1'b0, dq_diag}) : dv_sh[25:0];
    quo_next     = {quo[14:0], dv_ge};
  end

  always_comb begin
    sum_full = (acc + ACC_W'(32768)) >>> 16;
    if (sum_full > ACC_W'(SUM_MAX)) begin
      sum_sat  = 24'(SUM_MAX);
      sum_clip = 1'b1;
    end else if (sum_full < ACC_W'(SUM_MIN)) begin
      sum_sat  = 24'(SUM_MIN);
      sum_clip = 1'b1;
    end else begin
      sum_sat  = sum_full[23:0];
      sum_clip = 1'b0;
    end
  end

  always_comb begin
    cnt_ext   = {24'b0, electrode_count};
    count_eff = (cnt_ext > 32'(MAX_ELECTRODES)) ? MAX_CNT : cnt_ext[AW:0];
    wr_ext    = {25'b0, entry_index};
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready && opcode == OP_LOAD &&
        wr_ext < 32'(MAX_ELECTRODES)) begin
      mem[wr_ext[AW-1:0]] <= {elec_x & CMASK, elec_y & CMASK, elec_value};
    end
    rd_data <= mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width      <= 9'd64;
      grid_height     <= 9'd64;
      electrode_count <= 8'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GRID_WIDTH:      grid_width      <= cfg_data;
        REG_GRID_HEIGHT:     grid_height     <= cfg_data;
        REG_ELECTRODE_COUNT: electrode_count <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && opcode == OP_QUERY) begin
            px      <= pixel_x & CMASK;
            py      <= pixel_y & CMASK;
            count_q <= count_eff;
            state   <= S_GW;
          end
        end
        S_GW: state <= S_GH;
        S_GH: begin
          d2      <= prod[18:0];
          sq_diag <= 1'b1;
          state   <= S_DADD;
        end
        S_FETCH: state <= S_DX;
        S_DX: state <= S_DY;
        S_DY: begin
          d2      <= prod[18:0];
          sq_diag <= 1'b0;
          state   <= S_DADD;
        end
        S_DADD: begin
          rad    <= {1'b0, 19'(d2 + prod[18:0]), 32'b0};
          sq_rem <= '0;
          root   <= '0;
          step   <= '0;
          state  <= S_SQRT;
        end
        S_SQRT: begin
          sq_rem <= sq_rem_next;
          root   <= root_next;
          rad    <= {rad[49:0], 2'b00};
          step   <= step + 5'd1;
          if (step == 5'(SQRT_STEPS - 1)) begin
            if (sq_diag) begin
              dq_diag <= root_next;
              idx     <= '0;
              acc     <= '0;
              state   <= (count_q == '0) ? S_FINISH : S_FETCH;
            end else begin
              state <= S_CMP;
            end
          end
        end
        S_CMP: begin
          if (root >= dq_diag) begin
            w     <= '0;
            state <= S_MACMUL;
          end else begin
            div_rem <= root;
            quo     <= '0;
            step    <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          div_rem <= div_rem_next;
          quo     <= quo_next;
          step    <= step + 5'd1;
          if (step == 5'(DIV_STEPS - 1)) begin
            base  <= WEIGHT_ONE - {1'b0, quo_next};
            w     <= WEIGHT_ONE;
            step  <= '0;
            state <= S_POWMUL;
          end
        end
        S_POWMUL: state <= S_POWADD;
        S_POWADD: begin
          w    <= 17'((prod + 43'sd32768) >>> 16);
          step <= step + 5'd1;
          state <= (step == 5'(WEIGHT_POWER - 1)) ? S_MACMUL : S_POWMUL;
        end
        S_MACMUL: state <= S_MACADD;
        S_MACADD: begin
          acc   <= acc + ACC_W'(prod);
          idx   <= idx + 1'b1;
          state <= (idx + 1'b1 == count_q) ? S_FINISH : S_FETCH;
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            pixel_value <= sum_sat;
            saturated   <= sum_clip;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMP(div_rem_below_diag, clk, rst, state == S_DIV, div_rem < dq_diag)
  `ASSERT_IMP(fetch_in_range, clk, rst, state == S_FETCH, idx < count_q)
  `ASSERT_IMP(weight_bounded, clk, rst, state == S_POWMUL, w <= WEIGHT_ONE)
  `ASSERT_NEXT(query_blocks_input, clk, rst,
               in_valid && in_ready && opcode == OP_QUERY, !in_ready)

endmodule
